// File: design/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_SUB      = 3'd1,
    CMD_MUL      = 3'd2,
    CMD_DIV      = 3'd3,
    CMD_SIMPLIFY = 3'd4,
    CMD_NEGATE   = 3'd5,
    CMD_INVERT   = 3'd6,
    CMD_COMPARE  = 3'd7
  } cmd_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // capture operands
    OP_MUL1,       // first product pair
    OP_MUL2,       // second product pair
    OP_MUL3,       // denominator product a_den * b_den
    OP_FINISH,     // form arithmetic result
    OP_GCD_INIT,   // x = a_num, y = a_den, start remainder
    OP_DIV_STEP,   // one restoring division step
    OP_REM_DONE,   // advance euclid on remainder
    OP_QN_INIT,    // start a_num / g
    OP_QD_INIT,    // unused; a_den / g is started by OP_QN_DONE
    OP_QN_DONE,
    OP_QD_DONE,
    OP_SIMP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic rem_zero;   // remainder of euclid step is zero
    logic den_zero;   // a_den is zero
    logic div_last;   // last division step is running
  } stat_t;

endpackage

// File: design/rau_datapath.sv
// Datapath: operand registers, multiplier, shared iterative divider.
module rau_datapath (
  input  logic                                  clk,
  input  rau_pkg::ctrl_t                        ctrl,
  input  logic [2:0]                            cmd,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  a_num,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  a_den,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  b_num,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  b_den,
  output rau_pkg::stat_t                        stat,
  output logic signed [rau_pkg::WORD_BITS-1:0]  res_num,
  output logic signed [rau_pkg::WORD_BITS-1:0]  res_den,
  output logic                                  less_than,
  output logic                                  equal_to,
  output logic                                  zero_den_error
);

  localparam int W = rau_pkg::WORD_BITS;

  logic [2:0]          cmd_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [2*W-1:0] p0_r, p1_r, p2_r, p0_nxt, p1_nxt, p2_nxt;
  logic signed [W-1:0] ma, mb;
  // Euclid and division state (magnitudes with separate signs).
  logic signed [W-1:0] y_r;
  logic [W-1:0]        dvd_r, dvs_r, quo_r;
  logic [W:0]          rem_r;
  logic                qneg_r, rneg_r;
  logic [rau_pkg::CNT_BITS-1:0] cnt_r;
  logic signed [W-1:0] qn_r;
  logic signed [W-1:0] rn_r, rd_r;
  logic                lt_r, eq_r, err_r;
  logic [W:0]          trial;
  logic [W-1:0]        rem_next;
  logic signed [W-1:0] rem_signed, quo_signed;

  // Operand for the multiplier: b inverted and sign-normalized for divide.
  logic signed [W-1:0] dbn, dbd;
  always_comb begin
    dbn = bd_r;
    dbd = bn_r;
    if (bn_r < 0) begin
      dbn = -bd_r;
      dbd = -bn_r;
    end
  end

  // Product selection per command and pass.
  always_comb begin
    ma = an_r;
    mb = bd_r;
    case (ctrl.op)
      rau_pkg::OP_MUL1: begin
        case (cmd_r)
          rau_pkg::CMD_MUL: begin ma = an_r; mb = bn_r; end
          rau_pkg::CMD_DIV: begin ma = an_r; mb = dbn;  end
          default:          begin ma = an_r; mb = bd_r; end
        endcase
      end
      rau_pkg::OP_MUL2: begin
        case (cmd_r)
          rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_COMPARE: begin
            ma = bn_r; mb = ad_r;
          end
          rau_pkg::CMD_DIV: begin ma = ad_r; mb = dbd;  end
          default:          begin ma = ad_r; mb = bd_r; end
        endcase
      end
      // The third pass forms the common denominator.
      default: begin
        ma = ad_r; mb = bd_r;
      end
    endcase
  end

  // One 32x32 multiplier, up to three passes.
  always_comb begin
    p0_nxt = p0_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    if (ctrl.op == rau_pkg::OP_MUL1) p0_nxt = ma * mb;
    if (ctrl.op == rau_pkg::OP_MUL2) p1_nxt = ma * mb;
    if (ctrl.op == rau_pkg::OP_MUL3) p2_nxt = ma * mb;
  end

  // Restoring division step on magnitudes.
  assign trial    = {rem_r[W-1:0], dvd_r[W-1]} - {1'b0, dvs_r};
  assign rem_next = trial[W] ? {rem_r[W-2:0], dvd_r[W-1]} : trial[W-1:0];
  assign rem_signed = rneg_r ? -$signed(rem_r[W-1:0]) : $signed(rem_r[W-1:0]);
  assign quo_signed = qneg_r ? -$signed(quo_r) : $signed(quo_r);

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? W'(-v) : W'(v);
  endfunction

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
    case (ctrl.op)
      rau_pkg::OP_LOAD: begin
        cmd_r <= cmd; an_r <= a_num; ad_r <= a_den; bn_r <= b_num; bd_r <= b_den;
        lt_r <= 1'b0; eq_r <= 1'b0; err_r <= 1'b0;
      end
      rau_pkg::OP_FINISH: begin
        case (cmd_r)
          rau_pkg::CMD_ADD: begin
            rn_r <= W'(p0_r + p1_r); rd_r <= W'(p2_r);
          end
          rau_pkg::CMD_SUB: begin
            rn_r <= W'(p0_r - p1_r); rd_r <= W'(p2_r);
          end
          rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: begin
            rn_r <= W'(p0_r); rd_r <= W'(p1_r);
          end
          rau_pkg::CMD_NEGATE: begin
            rn_r <= -an_r; rd_r <= ad_r;
          end
          rau_pkg::CMD_INVERT: begin
            rn_r <= an_r[W-1] ? -ad_r : ad_r;
            rd_r <= an_r[W-1] ? -an_r : an_r;
          end
          rau_pkg::CMD_SIMPLIFY: begin
            rn_r <= an_r; rd_r <= ad_r; err_r <= 1'b1;
          end
          default: begin
            rn_r <= '0; rd_r <= '0;
            lt_r <= p0_r < p1_r;
            eq_r <= p0_r == p1_r;
          end
        endcase
      end
      rau_pkg::OP_GCD_INIT: begin
        y_r <= ad_r;
        dvd_r <= mag(an_r); dvs_r <= mag(ad_r); rem_r <= '0;
        rneg_r <= an_r[W-1]; qneg_r <= an_r[W-1] ^ ad_r[W-1];
        cnt_r <= '0;
      end
      rau_pkg::OP_DIV_STEP: begin
        rem_r <= {1'b0, rem_next};
        dvd_r <= {dvd_r[W-2:0], 1'b0};
        quo_r <= {quo_r[W-2:0], ~trial[W]};
        cnt_r <= cnt_r + 1'b1;
      end
      rau_pkg::OP_REM_DONE: begin
        // Next euclid pair: x = y, y = r.
        y_r <= rem_signed;
        dvd_r <= mag(y_r); dvs_r <= mag(rem_signed); rem_r <= '0;
        rneg_r <= y_r[W-1]; qneg_r <= y_r[W-1] ^ rem_signed[W-1];
        cnt_r <= '0;
      end
      rau_pkg::OP_QN_INIT: begin
        dvd_r <= mag(an_r); dvs_r <= mag(y_r); rem_r <= '0;
        rneg_r <= an_r[W-1]; qneg_r <= an_r[W-1] ^ y_r[W-1];
        cnt_r <= '0;
      end
      rau_pkg::OP_QN_DONE: begin
        qn_r <= quo_signed;
        dvd_r <= mag(ad_r); dvs_r <= mag(y_r); rem_r <= '0;
        rneg_r <= ad_r[W-1]; qneg_r <= ad_r[W-1] ^ y_r[W-1];
        cnt_r <= '0;
      end
      rau_pkg::OP_QD_DONE: begin
        rn_r <= quo_signed[W-1] ? -qn_r : qn_r;
        rd_r <= quo_signed[W-1] ? -quo_signed : quo_signed;
      end
      default: ;
    endcase
  end

  assign stat.rem_zero = (rem_r[W-1:0] == '0);
  assign stat.den_zero = (ad_r == '0);
  assign stat.div_last = (cnt_r == rau_pkg::CNT_BITS'(W - 1));

  assign res_num        = rn_r;
  assign res_den        = rd_r;
  assign less_than      = lt_r;
  assign equal_to       = eq_r;
  assign zero_den_error = err_r;

endmodule

// File: design/rau_ctrl.sv
// Controller: sequences the datapath for one transaction at a time.
module rau_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [2:0]     cmd,
  input  rau_pkg::stat_t stat,
  output rau_pkg::ctrl_t ctrl,
  output logic           out_valid,
  input  logic           out_stall
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_FIN, S_GINIT, S_GDIV, S_GCHK,
    S_QNDIV, S_QDDIV, S_QDDONE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   simp_r, simp_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    simp_nxt      = simp_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl.op       = rau_pkg::OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        ctrl.op   = rau_pkg::OP_LOAD;
        simp_nxt  = (cmd == rau_pkg::CMD_SIMPLIFY);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        ctrl.op = rau_pkg::OP_MUL1; state_nxt = S_MUL2;
      end
      S_MUL2: begin
        ctrl.op = rau_pkg::OP_MUL2;
        state_nxt = (simp_r && !stat.den_zero) ? S_GINIT : S_MUL3;
      end
      S_MUL3: begin
        ctrl.op = rau_pkg::OP_MUL3; state_nxt = S_FIN;
      end
      S_FIN: begin
        ctrl.op = rau_pkg::OP_FINISH; state_nxt = S_OUT;
      end
      S_GINIT: begin
        ctrl.op = rau_pkg::OP_GCD_INIT; state_nxt = S_GDIV;
      end
      S_GDIV: begin
        ctrl.op = rau_pkg::OP_DIV_STEP;
        if (stat.div_last) state_nxt = S_GCHK;
      end
      S_GCHK: begin
        // Zero remainder: y holds the gcd.
        if (stat.rem_zero) begin
          ctrl.op = rau_pkg::OP_QN_INIT; state_nxt = S_QNDIV;
        end else begin
          ctrl.op = rau_pkg::OP_REM_DONE; state_nxt = S_GDIV;
        end
      end
      S_QNDIV: begin
        ctrl.op = rau_pkg::OP_DIV_STEP;
        if (stat.div_last) state_nxt = S_QDDIV;
      end
      S_QDDIV: begin
        ctrl.op = rau_pkg::OP_QN_DONE; state_nxt = S_QDDONE;
      end
      S_QDDONE: begin
        ctrl.op = rau_pkg::OP_DIV_STEP;
        if (stat.div_last) state_nxt = S_FIN;
      end
      S_OUT: if (!(out_valid_r && out_stall)) begin
        out_valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // Final quotient of simplify replaces the generic finish.
    if (state_r == S_FIN && simp_r && !stat.den_zero) ctrl.op = rau_pkg::OP_QD_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      simp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      simp_r      <= simp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result only appears on leaving the output state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT) else $error("out_valid without S_OUT");
  // No transaction is taken while one is in progress.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  // Division runs only in its loop states.
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == rau_pkg::OP_DIV_STEP) |->
    (state_r == S_GDIV || state_r == S_QNDIV || state_r == S_QDDONE)) else $error("stray step");

endmodule

// File: design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// One transaction at a time: add, sub, mul, div, negate, invert, compare and
// simplify with a zero denominator present their result after the states
// MUL1, MUL2, MUL3, FIN and OUT (three passes through one 32x32 multiplier),
// and the next transaction can be accepted once the controller is idle and
// the output is not stalled; simplify presents its result after its Euclid
// remainder steps, each a run of the shared bit-serial divider plus a check,
// followed by the two quotient divisions.
module rational_arithmetic_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            in_cmd,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  in_a_num,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  in_a_den,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  in_b_num,
  input  logic signed [rau_pkg::WORD_BITS-1:0]  in_b_den,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rau_pkg::WORD_BITS-1:0]  out_res_num,
  output logic signed [rau_pkg::WORD_BITS-1:0]  out_res_den,
  output logic                                  out_less_than,
  output logic                                  out_equal_to,
  output logic                                  out_zero_den_error
);

  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(in_cmd), .stat(stat), .ctrl(ctrl), .out_valid(out_valid), .out_stall(out_stall)
  );

  rau_datapath u_dp (
    .clk(clk), .ctrl(ctrl), .cmd(in_cmd), .a_num(in_a_num), .a_den(in_a_den),
    .b_num(in_b_num), .b_den(in_b_den), .stat(stat), .res_num(out_res_num),
    .res_den(out_res_den), .less_than(out_less_than), .equal_to(out_equal_to),
    .zero_den_error(out_zero_den_error)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps

module tb;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 50;
  localparam int STUCK_LIMIT = 20000;

  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    word_t num;
    word_t den;
    logic  less_than;
    logic  equal_to;
    logic  zero_den_error;
  } frac_result_t;

  // Scoreboard: computes the expected fraction per input transaction and
  // checks results in order.
  class frac_scoreboard;
    frac_result_t expected_q[$];
    int errors;

    function frac_result_t compute(rau_pkg::cmd_t op, word_t an, word_t ad, word_t bn,
                                   word_t bd);
      longint x, y, r, g, lhs, rhs;
      word_t tn, td;
      frac_result_t e;
      e = '0;
      case (op)
        rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
          if (op == rau_pkg::CMD_SUB) bn = -bn;
          e.num = an * bd + bn * ad;
          e.den = ad * bd;
        end
        rau_pkg::CMD_MUL: begin
          e.num = an * bn;
          e.den = ad * bd;
        end
        rau_pkg::CMD_DIV: begin
          // Multiply by b inverted, sign carried by the numerator.
          tn = bd;
          td = bn;
          if (td < 0) begin
            tn = -tn;
            td = -td;
          end
          e.num = an * tn;
          e.den = ad * td;
        end
        rau_pkg::CMD_SIMPLIFY: begin
          if (ad == 0) begin
            e.num = an;
            e.den = ad;
            e.zero_den_error = 1'b1;
          end else begin
            // Euclid on truncated remainders, carried at 64 bits.
            x = an;
            y = ad;
            r = x % y;
            while (r != 0) begin
              x = y;
              y = r;
              r = x % y;
            end
            g = y;
            tn = word_t'(longint'(an) / g);
            td = word_t'(longint'(ad) / g);
            if (td < 0) begin
              tn = -tn;
              td = -td;
            end
            e.num = tn;
            e.den = td;
          end
        end
        rau_pkg::CMD_NEGATE: begin
          e.num = -an;
          e.den = ad;
        end
        rau_pkg::CMD_INVERT: begin
          tn = ad;
          td = an;
          if (td < 0) begin
            tn = -tn;
            td = -td;
          end
          e.num = tn;
          e.den = td;
        end
        default: begin
          lhs = longint'(an) * longint'(bd);
          rhs = longint'(bn) * longint'(ad);
          e.less_than = lhs < rhs;
          e.equal_to = lhs == rhs;
        end
      endcase
      return e;
    endfunction

    function void note_input(rau_pkg::cmd_t op, word_t an, word_t ad, word_t bn,
                             word_t bd);
      expected_q.push_back(compute(op, an, ad, bn, bd));
    endfunction

    function void check_result(frac_result_t got);
      frac_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding: num %0d den %0d", got.num, got.den);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.num !== e.num) begin
        $error("res_num: expected %0d, actual %0d", e.num, got.num);
        errors++;
      end
      if (got.den !== e.den) begin
        $error("res_den: expected %0d, actual %0d", e.den, got.den);
        errors++;
      end
      if (got.less_than !== e.less_than) begin
        $error("less_than: expected %0b, actual %0b", e.less_than, got.less_than);
        errors++;
      end
      if (got.equal_to !== e.equal_to) begin
        $error("equal_to: expected %0b, actual %0b", e.equal_to, got.equal_to);
        errors++;
      end
      if (got.zero_den_error !== e.zero_den_error) begin
        $error("zero_den_error: expected %0b, actual %0b", e.zero_den_error,
               got.zero_den_error);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  word_t in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t out_res_num, out_res_den;
  logic out_less_than, out_equal_to, out_zero_den_error;

  frac_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  rational_arithmetic_unit dut (.*);

  always #HALF_PERIOD clk = ~clk;

  // Monitor both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input(rau_pkg::cmd_t'(in_cmd), in_a_num, in_a_den, in_b_num, in_b_den);
      if (out_valid && !out_stall)
        sb.check_result({out_res_num, out_res_den, out_less_than, out_equal_to,
                         out_zero_den_error});
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction and wait until it is accepted.
  task automatic send(rau_pkg::cmd_t op, word_t an, word_t ad, word_t bn, word_t bd);
    @(negedge clk);
    in_cmd <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Mix of full-range, small and boundary operands.
  function automatic word_t pick_word();
    case ($urandom_range(0, 4))
      0: return word_t'($urandom_range(0, 200)) - 100;
      1: begin
        case ($urandom_range(0, 4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return word_t'($urandom());
    endcase
  endfunction

  initial begin
    rau_pkg::cmd_t op;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every command, boundary operands and the special cases.
    send(rau_pkg::CMD_ADD, MOST_POS, 1, MOST_POS, 1);
    send(rau_pkg::CMD_ADD, 1, 2, 1, 3);
    send(rau_pkg::CMD_SUB, MOST_NEG, 1, MOST_NEG, 1);
    send(rau_pkg::CMD_SUB, 3, 4, 1, 4);
    send(rau_pkg::CMD_MUL, MOST_NEG, -1, MOST_POS, MOST_NEG);
    send(rau_pkg::CMD_DIV, 2, 3, -5, 7);
    send(rau_pkg::CMD_DIV, 2, 3, 5, MOST_NEG);
    send(rau_pkg::CMD_DIV, 1, 1, 0, 0);
    send(rau_pkg::CMD_SIMPLIFY, 12, 18, 0, 0);
    send(rau_pkg::CMD_SIMPLIFY, 12, -18, 0, 0);
    send(rau_pkg::CMD_SIMPLIFY, 7, 0, 0, 0);
    send(rau_pkg::CMD_SIMPLIFY, MOST_NEG, -1, 0, 0);
    send(rau_pkg::CMD_SIMPLIFY, 0, -5, 0, 0);
    send(rau_pkg::CMD_SIMPLIFY, MOST_NEG, MOST_NEG, 0, 0);
    send(rau_pkg::CMD_SIMPLIFY, 1836311903, 1134903170, 0, 0);
    send(rau_pkg::CMD_NEGATE, MOST_NEG, 3, 0, 0);
    send(rau_pkg::CMD_NEGATE, MOST_POS, -1, 0, 0);
    send(rau_pkg::CMD_INVERT, -3, 4, 0, 0);
    send(rau_pkg::CMD_INVERT, 3, MOST_NEG, 0, 0);
    send(rau_pkg::CMD_COMPARE, 1, 2, 2, 4);
    send(rau_pkg::CMD_COMPARE, -1, 2, 1, 2);
    send(rau_pkg::CMD_COMPARE, MOST_NEG, 1, MOST_POS, 1);
    send(rau_pkg::CMD_COMPARE, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);

    // Sender pauses until every outstanding result has come back.
    pause(1);
    wait_drained();

    // Random phase: one long receiver hold-off while the sender keeps offering, a drain midway and a quiet tail.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_request = 1'b1;
      if (i == 200) begin
        pause(1);
        wait_drained();
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      op = rau_pkg::cmd_t'($urandom_range(0, 7));
      send(op, pick_word(), pick_word(), pick_word(), pick_word());
      if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
    end
    pause(1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
